>>> hw/rtl/dsf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsf_pkg
// Shared types, constants and tables of the discrete-summation oscillator.
// ----------------------------------------------------------------------------
package dsf_pkg;

  localparam int PHASE_BITS    = 16;
  localparam int OUT_BITS      = 16;
  localparam int FRAC_BITS     = OUT_BITS - 1;
  localparam int DCNT_BITS     = $clog2(OUT_BITS);
  localparam int MAX_OVERTONES = 255;
  localparam int OVT_BITS      = $clog2(MAX_OVERTONES + 1);

  // Q.30 datapath values, magnitudes and the split multiplier halves
  localparam int VW      = 36;
  localparam int MW      = VW - 1;
  localparam int MLO     = 18;
  localparam int MHI     = MW - MLO;
  localparam int QSHIFT  = 30;
  localparam logic signed [VW-1:0] QONE = VW'(64'd1 << QSHIFT);

  // CORDIC
  localparam int CW           = 34;
  localparam int CORDIC_STEPS = 28;
  localparam int CIT_BITS     = $clog2(CORDIC_STEPS);
  localparam logic signed [CW-1:0] CORDIC_X0 = CW'(64'd652032874);

  // Sequencing
  localparam int NUM_COR  = 5;
  localparam int NUM_MUL  = 7;
  localparam int SEQ_BITS = 3;

  typedef struct packed {
    logic [PHASE_BITS-1:0] phase_turns;
    logic [15:0]           mod_ratio;
    logic [15:0]           intensity;
    logic [7:0]            overtone_count;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_BITS-1:0] sample_out;
    logic                       degenerate;
  } out_item_t;

  typedef enum logic [2:0] {
    ANG_T_N1S, ANG_T_NS, ANG_T, ANG_T_MS, ANG_S, ANG_N1S, ANG_NS
  } ang_sel_e;

  typedef enum logic [2:0] {
    MU_AA, MU_IN, MU_M2, MU_M3, MU_N1, MU_D, MU_P, MU_Q
  } mul_op_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CALC_S, ST_CALC_NS, ST_COR_GO, ST_COR_WAIT, ST_POW_WAIT,
    ST_MUL_GO, ST_MUL_WAIT, ST_DIV_GO, ST_DIV_WAIT, ST_OUT
  } state_e;

  typedef struct packed {
    logic                load;
    logic                calc_s;
    logic                calc_ns;
    logic                cor_go;
    ang_sel_e            ang;
    logic [SEQ_BITS-1:0] cor_dst;
    logic                cor_cos;
    logic                mul_go;
    mul_op_e             op;
    logic                div_go;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mode;
    logic pow_done;
    logic cor_done;
    logic mul_done;
    logic div_done;
  } dp_status_t;

  // atan(2^-i) in Q0.32 turns
  function automatic logic [31:0] atan_turns(input logic [CIT_BITS-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

  // Sin/cos evaluation order; result k lands in slot k
  function automatic ang_sel_e cor_angle(input logic mode, input logic [SEQ_BITS-1:0] k);
    ang_sel_e a;
    case (k)
      3'd0:    a = mode ? ANG_N1S : ANG_T_N1S;
      3'd1:    a = mode ? ANG_NS  : ANG_T_NS;
      3'd2:    a = ANG_T;
      3'd3:    a = ANG_T_MS;
      default: a = ANG_S;
    endcase
    return a;
  endfunction

  function automatic logic cor_use_cos(input logic mode, input logic [SEQ_BITS-1:0] k);
    logic c;
    case (k)
      3'd0, 3'd1: c = mode;
      3'd4:       c = 1'b1;
      default:    c = 1'b0;
    endcase
    return c;
  endfunction

  // Multiply order for the one-sided and two-sided sums
  function automatic mul_op_e mul_step(input logic mode, input logic [SEQ_BITS-1:0] k);
    mul_op_e o;
    case (k)
      3'd0:    o = MU_AA;
      3'd1:    o = MU_IN;
      3'd2:    o = mode ? MU_M3 : MU_M2;
      3'd3:    o = mode ? MU_N1 : MU_M3;
      3'd4:    o = MU_D;
      3'd5:    o = MU_P;
      default: o = MU_Q;
    endcase
    return o;
  endfunction

  function automatic logic [MW-1:0] mag(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] n;
    n = -v;
    return v[VW-1] ? n[MW-1:0] : v[MW-1:0];
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/dsf_oscillator_sample.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsf_oscillator_sample
// Discrete-summation-formula band-limited oscillator, one sample per command.
// ----------------------------------------------------------------------------
// Sequence per command: angle setup (CALC_S, CALC_NS), five CORDIC runs,
// seven multiplies and a restoring divide; the divide is skipped when the
// result saturates or degenerates. The a^(n+1) loop runs one multiply per
// cycle alongside, and the multiplies wait for it to finish. A new command
// is taken only once busy is low again, after the result strobe.
// Reset clears the controller and sum_mode; the result is not held off.
module dsf_oscillator_sample (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                start,
  output logic               busy,
  input  dsf_pkg::in_item_t  in_i,
  input  wire                cfg_we_i,
  input  wire                cfg_data_i,
  output logic               out_valid_o,
  output dsf_pkg::out_item_t out_o
);

  dsf_pkg::ctrl_cmd_t  cmd;
  dsf_pkg::dp_status_t status;

  // sequencer
  dsf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // arithmetic
  dsf_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_i       (in_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .out_o      (out_o)
  );

endmodule
`default_nettype wire

>>> hw/rtl/dsf_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsf_ctrl
// Sequencer: steps the datapath through angles, CORDIC runs, multiplies and
// the final division.
// ----------------------------------------------------------------------------
module dsf_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 start,
  output logic                busy,
  output logic                out_valid_o,
  output dsf_pkg::ctrl_cmd_t  cmd_o,
  input  dsf_pkg::dp_status_t status_i
);

  dsf_pkg::state_e state_q, state_d;
  logic [dsf_pkg::SEQ_BITS-1:0] k_q, k_d;

  // state and step index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dsf_pkg::ST_IDLE;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    case (state_q)
      dsf_pkg::ST_IDLE: begin
        k_d = '0;
        if (start) state_d = dsf_pkg::ST_CALC_S;
      end
      dsf_pkg::ST_CALC_S:  state_d = dsf_pkg::ST_CALC_NS;
      dsf_pkg::ST_CALC_NS: state_d = dsf_pkg::ST_COR_GO;
      dsf_pkg::ST_COR_GO:  state_d = dsf_pkg::ST_COR_WAIT;
      dsf_pkg::ST_COR_WAIT: begin
        if (status_i.cor_done) begin
          if (k_q == dsf_pkg::SEQ_BITS'(dsf_pkg::NUM_COR - 1)) begin
            k_d     = '0;
            state_d = dsf_pkg::ST_POW_WAIT;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = dsf_pkg::ST_COR_GO;
          end
        end
      end
      dsf_pkg::ST_POW_WAIT: begin
        if (status_i.pow_done) state_d = dsf_pkg::ST_MUL_GO;
      end
      dsf_pkg::ST_MUL_GO: state_d = dsf_pkg::ST_MUL_WAIT;
      dsf_pkg::ST_MUL_WAIT: begin
        if (status_i.mul_done) begin
          if (k_q == dsf_pkg::SEQ_BITS'(dsf_pkg::NUM_MUL - 1)) begin
            k_d     = '0;
            state_d = dsf_pkg::ST_DIV_GO;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = dsf_pkg::ST_MUL_GO;
          end
        end
      end
      dsf_pkg::ST_DIV_GO: state_d = dsf_pkg::ST_DIV_WAIT;
      dsf_pkg::ST_DIV_WAIT: begin
        if (status_i.div_done) state_d = dsf_pkg::ST_OUT;
      end
      dsf_pkg::ST_OUT: state_d = dsf_pkg::ST_IDLE;
      default: state_d = dsf_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o         = '0;
    cmd_o.ang     = dsf_pkg::cor_angle(status_i.mode, k_q);
    cmd_o.cor_dst = k_q;
    cmd_o.cor_cos = dsf_pkg::cor_use_cos(status_i.mode, k_q);
    cmd_o.op      = dsf_pkg::mul_step(status_i.mode, k_q);
    busy          = (state_q != dsf_pkg::ST_IDLE);
    out_valid_o   = 1'b0;
    case (state_q)
      dsf_pkg::ST_IDLE:    cmd_o.load    = start;
      dsf_pkg::ST_CALC_S:  cmd_o.calc_s  = 1'b1;
      dsf_pkg::ST_CALC_NS: cmd_o.calc_ns = 1'b1;
      dsf_pkg::ST_COR_GO:  cmd_o.cor_go  = 1'b1;
      dsf_pkg::ST_MUL_GO:  cmd_o.mul_go  = 1'b1;
      dsf_pkg::ST_DIV_GO:  cmd_o.div_go  = 1'b1;
      dsf_pkg::ST_OUT:     out_valid_o   = 1'b1;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> hw/rtl/dsf_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dsf_datapath
// Angle setup, a^(n+1) loop, iterative CORDIC, two-pass sign-magnitude
// multiplier and restoring divider for the oscillator sample.
// ----------------------------------------------------------------------------
module dsf_datapath (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  dsf_pkg::ctrl_cmd_t  cmd_i,
  output dsf_pkg::dp_status_t status_o,
  input  dsf_pkg::in_item_t   in_i,
  input  wire                 cfg_we_i,
  input  wire                 cfg_data_i,
  output dsf_pkg::out_item_t  out_o
);

  localparam int VW = dsf_pkg::VW;
  localparam int MW = dsf_pkg::MW;
  localparam int CW = dsf_pkg::CW;
  localparam int PB = dsf_pkg::PHASE_BITS;
  localparam int FB = dsf_pkg::FRAC_BITS;

  // configuration and input item
  logic                         mode_q;
  logic [PB-1:0]                phase_q;
  logic [15:0]                  ratio_q, a16_q;
  logic [dsf_pkg::OVT_BITS-1:0] ovt_q;
  logic [dsf_pkg::OVT_BITS-1:0] ovt_cl;

  always_comb begin
    ovt_cl = (in_i.overtone_count > dsf_pkg::MAX_OVERTONES) ?
             dsf_pkg::OVT_BITS'(dsf_pkg::MAX_OVERTONES) :
             dsf_pkg::OVT_BITS'(in_i.overtone_count);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      mode_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      phase_q <= in_i.phase_turns;
      ratio_q <= in_i.mod_ratio;
      a16_q   <= in_i.intensity;
      ovt_q   <= ovt_cl;
    end
  end

  // angles in Q0.32 turns
  logic [31:0] t_w, s_q, ns_q, n1s_w, ang_w;
  logic [47:0] rt_w;
  logic [39:0] ns_w;

  assign t_w   = 32'(phase_q) << (32 - PB);
  assign rt_w  = 48'(ratio_q) * 48'(t_w);
  assign ns_w  = 40'(ovt_q) * 40'(s_q);
  assign n1s_w = ns_q + s_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_s)  s_q  <= rt_w[39:8];
    if (cmd_i.calc_ns) ns_q <= ns_w[31:0];
  end

  always_comb begin
    case (cmd_i.ang)
      dsf_pkg::ANG_T_N1S: ang_w = t_w + n1s_w;
      dsf_pkg::ANG_T_NS:  ang_w = t_w + ns_q;
      dsf_pkg::ANG_T:     ang_w = t_w;
      dsf_pkg::ANG_T_MS:  ang_w = t_w - s_q;
      dsf_pkg::ANG_S:     ang_w = s_q;
      dsf_pkg::ANG_N1S:   ang_w = n1s_w;
      dsf_pkg::ANG_NS:    ang_w = ns_q;
      default:            ang_w = t_w;
    endcase
  end

  // a^(n+1): one truncating multiply per cycle, runs from the input transfer
  logic [31:0]                  pw_q;
  logic [dsf_pkg::OVT_BITS-1:0] pcnt_q;
  logic [47:0]                  pw_prod;

  assign pw_prod = 48'(pw_q) * 48'(a16_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcnt_q <= '0;
    end else if (cmd_i.load) begin
      pcnt_q <= ovt_cl;
    end else if (pcnt_q != '0) begin
      pcnt_q <= pcnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      pw_q <= {in_i.intensity, 16'h0000};
    end else if (pcnt_q != '0) begin
      pw_q <= pw_prod[47:16];
    end
  end

  // CORDIC, one micro-rotation per cycle
  logic                          cor_busy_q, cor_done_q;
  logic [dsf_pkg::CIT_BITS-1:0]  cit_q;
  logic signed [CW-1:0]          cx_q, cy_q, cz_q;
  logic [1:0]                    cq_q;
  logic [dsf_pkg::SEQ_BITS-1:0]  cdst_q;
  logic                          ccos_q;
  logic [1:0]                    q_w;
  logic [31:0]                   r_w, qo_w;
  logic signed [CW-1:0]          dx_w, dy_w, at_w;
  logic signed [VW-1:0]          xe_w, ye_w, sin_w, cos_w;
  logic signed [VW-1:0]          c_q [dsf_pkg::NUM_COR];

  assign qo_w = ang_w + 32'h2000_0000;
  assign q_w  = qo_w[31:30];
  assign r_w  = ang_w - {q_w, 30'h0};
  assign dx_w = cy_q >>> cit_q;
  assign dy_w = cx_q >>> cit_q;
  assign at_w = signed'(CW'(dsf_pkg::atan_turns(cit_q)));
  assign xe_w = {{(VW-CW){cx_q[CW-1]}}, cx_q};
  assign ye_w = {{(VW-CW){cy_q[CW-1]}}, cy_q};

  // quadrant rotation
  always_comb begin
    case (cq_q)
      2'd0:    begin cos_w = xe_w;  sin_w = ye_w;  end
      2'd1:    begin cos_w = -ye_w; sin_w = xe_w;  end
      2'd2:    begin cos_w = -xe_w; sin_w = -ye_w; end
      default: begin cos_w = ye_w;  sin_w = -xe_w; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cor_busy_q <= 1'b0;
      cor_done_q <= 1'b0;
      cit_q      <= '0;
    end else begin
      cor_done_q <= 1'b0;
      if (cmd_i.cor_go) begin
        cor_busy_q <= 1'b1;
        cit_q      <= '0;
      end else if (cor_busy_q) begin
        cit_q <= cit_q + 1'b1;
        if (cit_q == dsf_pkg::CIT_BITS'(dsf_pkg::CORDIC_STEPS - 1)) begin
          cor_busy_q <= 1'b0;
          cor_done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cor_go) begin
      cx_q   <= dsf_pkg::CORDIC_X0;
      cy_q   <= '0;
      cz_q   <= {{(CW-32){r_w[31]}}, r_w};
      cq_q   <= q_w;
      cdst_q <= cmd_i.cor_dst;
      ccos_q <= cmd_i.cor_cos;
    end else if (cor_busy_q) begin
      if (!cz_q[CW-1]) begin
        cx_q <= cx_q - dx_w;
        cy_q <= cy_q + dy_w;
        cz_q <= cz_q - at_w;
      end else begin
        cx_q <= cx_q + dx_w;
        cy_q <= cy_q - dy_w;
        cz_q <= cz_q + at_w;
      end
    end
    if (cor_done_q) begin
      c_q[cdst_q] <= ccos_q ? cos_w : sin_w;
    end
  end

  // Q.30 operands
  logic signed [VW-1:0] a_w, a1_w, ds_w, ox_w, oy_w;
  logic signed [VW-1:0] aa_q, inner_q, nn_q, dd_q, pp_q, qq_q;

  assign a_w  = signed'({{(VW-30){1'b0}}, a16_q, 14'h0});
  assign a1_w = signed'({{(VW-30){1'b0}}, pw_q[31:2]});
  assign ds_w = mode_q ? ((a1_w <<< 1) - a_w - dsf_pkg::QONE) : (a1_w - dsf_pkg::QONE);

  always_comb begin
    case (cmd_i.op)
      dsf_pkg::MU_AA: begin ox_w = a_w;                        oy_w = a_w;     end
      dsf_pkg::MU_IN: begin ox_w = a_w;                        oy_w = c_q[1];  end
      dsf_pkg::MU_M2: begin ox_w = a_w;                        oy_w = c_q[3];  end
      dsf_pkg::MU_M3: begin ox_w = mode_q ? (a1_w <<< 1) : a1_w; oy_w = inner_q; end
      dsf_pkg::MU_N1: begin ox_w = c_q[2];                     oy_w = nn_q;    end
      dsf_pkg::MU_D:  begin ox_w = a_w;                        oy_w = c_q[4];  end
      dsf_pkg::MU_P:  begin ox_w = a_w - dsf_pkg::QONE;        oy_w = nn_q;    end
      dsf_pkg::MU_Q:  begin ox_w = ds_w;                       oy_w = dd_q;    end
      default:        begin ox_w = a_w;                        oy_w = a_w;     end
    endcase
  end

  // multiplier: low partial, high partial, then sum and write back
  logic                    mv1_q, mv2_q, mv3_q, mneg_q;
  dsf_pkg::mul_op_e        mop_q;
  logic [MW-1:0]           mx_q, my_q;
  logic [MW+dsf_pkg::MLO-1:0] lo_q;
  logic [MW+dsf_pkg::MHI-1:0] hi_q;
  logic [2*MW-1:0]         msum_w;
  logic [MW-1:0]           rmag_w;
  logic signed [VW-1:0]    r_sgn_w;

  assign msum_w  = (2*MW)'(lo_q) + ((2*MW)'(hi_q) << dsf_pkg::MLO);
  assign rmag_w  = msum_w[dsf_pkg::QSHIFT +: MW];
  assign r_sgn_w = mneg_q ? -signed'({1'b0, rmag_w}) : signed'({1'b0, rmag_w});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mv1_q <= 1'b0;
      mv2_q <= 1'b0;
      mv3_q <= 1'b0;
    end else begin
      mv1_q <= cmd_i.mul_go;
      mv2_q <= mv1_q;
      mv3_q <= mv2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_go) begin
      mx_q   <= dsf_pkg::mag(ox_w);
      my_q   <= dsf_pkg::mag(oy_w);
      mneg_q <= ox_w[VW-1] ^ oy_w[VW-1];
      mop_q  <= cmd_i.op;
    end
    if (mv1_q) lo_q <= (MW+dsf_pkg::MLO)'(mx_q * my_q[dsf_pkg::MLO-1:0]);
    if (mv2_q) hi_q <= (MW+dsf_pkg::MHI)'(mx_q * my_q[MW-1:dsf_pkg::MLO]);
    if (mv3_q) begin
      case (mop_q)
        dsf_pkg::MU_AA: aa_q    <= r_sgn_w;
        dsf_pkg::MU_IN: inner_q <= c_q[0] - r_sgn_w;
        dsf_pkg::MU_M2: nn_q    <= c_q[2] - r_sgn_w;
        dsf_pkg::MU_M3: nn_q    <= mode_q ? (dsf_pkg::QONE - aa_q - r_sgn_w)
                                          : (nn_q - r_sgn_w);
        dsf_pkg::MU_N1: nn_q    <= r_sgn_w;
        dsf_pkg::MU_D:  dd_q    <= dsf_pkg::QONE + aa_q - (r_sgn_w <<< 1);
        dsf_pkg::MU_P:  pp_q    <= r_sgn_w;
        dsf_pkg::MU_Q:  qq_q    <= r_sgn_w;
        default: ;
      endcase
    end
  end

  // restoring divider for the output fraction
  logic                       dbusy_q, ddone_q, dneg_q;
  logic [dsf_pkg::DCNT_BITS-1:0] dcnt_q;
  logic [MW-1:0]              rem_q, den_q, p_mag_w, q_mag_w;
  logic [FB-1:0]              dm_q, m_fin_w;
  logic [MW:0]                rem2_w;
  logic                       dbit_w;
  logic signed [dsf_pkg::OUT_BITS-1:0] smax_w, smin_w, sdiv_w;

  assign p_mag_w = dsf_pkg::mag(pp_q);
  assign q_mag_w = dsf_pkg::mag(qq_q);
  assign rem2_w  = {rem_q, 1'b0};
  assign dbit_w  = (rem2_w >= {1'b0, den_q});
  assign m_fin_w = {dm_q[FB-2:0], dbit_w};
  assign smax_w  = signed'({1'b0, {FB{1'b1}}});
  assign smin_w  = signed'({1'b1, {FB{1'b0}}});
  assign sdiv_w  = dneg_q ? -signed'({1'b0, m_fin_w}) : signed'({1'b0, m_fin_w});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dbusy_q <= 1'b0;
      ddone_q <= 1'b0;
      dcnt_q  <= '0;
    end else begin
      ddone_q <= 1'b0;
      if (cmd_i.div_go) begin
        dcnt_q <= '0;
        if (qq_q == '0 || p_mag_w >= q_mag_w) begin
          ddone_q <= 1'b1;
        end else begin
          dbusy_q <= 1'b1;
        end
      end else if (dbusy_q) begin
        dcnt_q <= dcnt_q + 1'b1;
        if (dcnt_q == dsf_pkg::DCNT_BITS'(FB - 1)) begin
          dbusy_q <= 1'b0;
          ddone_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_go) begin
      rem_q  <= p_mag_w;
      den_q  <= q_mag_w;
      dm_q   <= '0;
      dneg_q <= pp_q[VW-1] ^ qq_q[VW-1];
      if (qq_q == '0) begin
        out_o.sample_out <= '0;
        out_o.degenerate <= 1'b1;
      end else if (p_mag_w >= q_mag_w) begin
        out_o.sample_out <= (pp_q[VW-1] ^ qq_q[VW-1]) ? smin_w : smax_w;
        out_o.degenerate <= 1'b0;
      end
    end else if (dbusy_q) begin
      rem_q <= dbit_w ? MW'(rem2_w - {1'b0, den_q}) : rem2_w[MW-1:0];
      dm_q  <= m_fin_w;
      if (dcnt_q == dsf_pkg::DCNT_BITS'(FB - 1)) begin
        out_o.sample_out <= sdiv_w;
        out_o.degenerate <= 1'b0;
      end
    end
  end

  assign status_o.mode     = mode_q;
  assign status_o.pow_done = (pcnt_q == '0);
  assign status_o.cor_done = cor_done_q;
  assign status_o.mul_done = mv3_q;
  assign status_o.div_done = ddone_q;

endmodule
`default_nettype wire

>>> bench/tb_dsf_oscillator_sample.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dsf_oscillator_sample
// Self-checking bench: bursty command driver, result monitor and a bit-exact
// fixed-point predictor of the one-sided and two-sided summation oscillator.
// ----------------------------------------------------------------------------
module tb_dsf_oscillator_sample;

  typedef enum logic [1:0] {CMD_SAMPLE, CMD_MODE, CMD_DRAIN} cmd_kind_e;
  typedef struct {
    cmd_kind_e          kind;
    logic               mode;
    dsf_pkg::in_item_t  item;
  } cmd_t;

  localparam longint ONE_Q30 = 64'sd1 << 30;
  localparam longint COR_X0  = 64'sd652032874;
  localparam longint ATAN_TBL [28] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465, 10679838,
    5340245, 2670163, 1335087, 667544, 333772, 166886, 83443, 41722, 20861,
    10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5};

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  dsf_pkg::in_item_t  in_i = '0;
  logic               cfg_we_i = 1'b0;
  logic               cfg_data_i = 1'b0;
  logic               out_valid_o;
  dsf_pkg::out_item_t out_o;

  cmd_t               cmd_q[$];
  dsf_pkg::out_item_t sample_exp_q[$];
  logic               mode_shadow = 1'b0;
  int                 err_cnt = 0;
  int                 burst_left = 0;
  int                 gap_left = 0;
  int                 quiet_cnt = 0;

  dsf_oscillator_sample uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .in_i(in_i),
    .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i), .out_valid_o(out_valid_o),
    .out_o(out_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Q.30 sign-magnitude helpers
  function automatic longint unsigned abs_q(input longint v);
    return v < 0 ? 64'd0 - longint'(v) : longint'(v);
  endfunction

  function automatic longint mul_q30(input longint x, input longint y);
    longint unsigned p;
    p = (abs_q(x) * abs_q(y)) >> 30;
    return ((x < 0) != (y < 0)) ? -longint'(p) : longint'(p);
  endfunction

  // CORDIC sin/cos of a Q0.32 angle in turns
  function automatic void cordic_turns(input logic [31:0] ang, output longint sn,
                                       output longint cs);
    logic [31:0] q, r, quarter;
    longint x, y, z, dx, dy;
    quarter = ang + 32'h2000_0000;
    q = {30'd0, quarter[31:30]};
    r = ang - (q << 30);
    z = longint'($signed(r));
    x = COR_X0;
    y = 0;
    for (int i = 0; i < 28; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TBL[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TBL[i];
      end
    end
    case (q[1:0])
      2'd0: begin cs = x;  sn = y;  end
      2'd1: begin cs = -y; sn = x;  end
      2'd2: begin cs = -x; sn = -y; end
      default: begin cs = y; sn = -x; end
    endcase
  endfunction

  function automatic longint sin_q(input logic [31:0] ang);
    longint s, c;
    cordic_turns(ang, s, c);
    return s;
  endfunction

  function automatic longint cos_q(input logic [31:0] ang);
    longint s, c;
    cordic_turns(ang, s, c);
    return c;
  endfunction

  // Expected sample for one command under the given sum mode
  function automatic dsf_pkg::out_item_t dsf_sample(input dsf_pkg::in_item_t it,
                                                    input logic sym_mode);
    dsf_pkg::out_item_t r;
    logic [31:0] t, s, ns, n1s;
    longint unsigned a32, pw, rem, den, m, n;
    longint a, a1, aa, num, ds, d, pq, qq, inner;
    logic neg;
    n = it.overtone_count;
    t = {it.phase_turns, 16'd0};
    s = 32'((longint'(it.mod_ratio) * longint'(t)) >> 8);
    ns = 32'(n * s);
    n1s = 32'((n + 1) * s);
    a32 = longint'(it.intensity) << 16;
    pw = a32;
    for (int i = 0; i < n; i++) pw = (pw * a32) >> 32;
    a = longint'(it.intensity) << 14;
    a1 = longint'(pw >> 2);
    aa = mul_q30(a, a);
    if (!sym_mode) begin
      inner = sin_q(t + n1s) - mul_q30(a, sin_q(t + ns));
      num = sin_q(t) - mul_q30(a, sin_q(t - s)) - mul_q30(a1, inner);
      ds = a1 - ONE_Q30;
    end else begin
      inner = cos_q(n1s) - mul_q30(a, cos_q(ns));
      num = mul_q30(sin_q(t), ONE_Q30 - aa - mul_q30(2 * a1, inner));
      ds = 2 * a1 - a - ONE_Q30;
    end
    d = ONE_Q30 + aa - 2 * mul_q30(a, cos_q(s));
    pq = mul_q30(a - ONE_Q30, num);
    qq = mul_q30(ds, d);
    r = '0;
    if (qq == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    neg = (pq < 0) != (qq < 0);
    rem = abs_q(pq);
    den = abs_q(qq);
    if (rem >= den) begin
      m = neg ? 64'd32768 : 64'd32767;
    end else begin
      m = 0;
      for (int i = 0; i < 15; i++) begin
        rem <<= 1;
        m <<= 1;
        if (rem >= den) begin
          rem -= den;
          m |= 1;
        end
      end
    end
    r.sample_out = 16'(neg ? 64'd0 - m : m);
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    err_cnt++;
  endtask

  task automatic push_sample(input logic [15:0] ph, input logic [15:0] ra,
                             input logic [15:0] a, input logic [7:0] n);
    cmd_t c;
    c.kind = CMD_SAMPLE;
    c.mode = 1'b0;
    c.item = '{phase_turns: ph, mod_ratio: ra, intensity: a, overtone_count: n};
    cmd_q.push_back(c);
  endtask

  task automatic push_ctrl(input cmd_kind_e k, input logic md);
    cmd_t c;
    c.kind = k;
    c.mode = md;
    c.item = '0;
    cmd_q.push_back(c);
  endtask

  // Random sample: mostly small overtone counts, a few up to the maximum
  task automatic push_random;
    logic [7:0] n;
    logic [15:0] a;
    case ($urandom_range(0, 9))
      0:       n = 8'($urandom_range(0, 255));
      1:       n = 8'($urandom_range(200, 255));
      default: n = 8'($urandom_range(0, 40));
    endcase
    case ($urandom_range(0, 7))
      0:       a = 16'($urandom_range(65000, 65535));
      1:       a = 16'($urandom_range(0, 255));
      default: a = 16'($urandom);
    endcase
    push_sample(16'($urandom), 16'($urandom), a, n);
  endtask

  // Stimulus plan
  initial begin
    logic [1:0] md;
    // directed: one-sided
    push_sample(16'h0000, 16'h0100, 16'h8000, 8'd4);
    push_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255);
    push_sample(16'h4000, 16'h0000, 16'h0000, 8'd0);
    push_sample(16'h8000, 16'h0100, 16'hFFFF, 8'd0);
    push_sample(16'h1234, 16'h0000, 16'hFFFF, 8'd1);
    push_sample(16'hC000, 16'h0280, 16'hF000, 8'd255);
    push_sample(16'h2000, 16'h0100, 16'h0001, 8'd7);
    push_sample(16'h5555, 16'hAAAA, 16'h5555, 8'd170);
    push_sample(16'hAAAA, 16'h5555, 16'hAAAA, 8'd85);
    push_sample(16'h0001, 16'h0001, 16'hFFFE, 8'd2);
    push_ctrl(CMD_DRAIN, 1'b0);
    // directed: two-sided
    push_ctrl(CMD_MODE, 1'b1);
    push_sample(16'h0000, 16'h0100, 16'h8000, 8'd4);
    push_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd255);
    push_sample(16'h4000, 16'h0000, 16'h0000, 8'd0);
    push_sample(16'h8000, 16'h0100, 16'hFFFF, 8'd0);
    push_sample(16'h1234, 16'h0000, 16'hFFFF, 8'd1);
    push_sample(16'h4000, 16'h0100, 16'hFFFF, 8'd3);
    push_sample(16'h5555, 16'hAAAA, 16'h5555, 8'd170);
    push_sample(16'hAAAA, 16'h5555, 16'hAAAA, 8'd85);
    // random phases, each under a random or alternating mode
    for (int ph = 0; ph < 8; ph++) begin
      md = (ph < 2) ? 2'(ph) : 2'($urandom_range(0, 1));
      push_ctrl(CMD_MODE, md[0]);
      for (int i = 0; i < 66; i++) push_random();
      if (ph == 4) push_ctrl(CMD_DRAIN, 1'b0);
    end
  end

  // Driver: bursts of commands, mode writes only once the block has gone quiet
  always @(posedge clk_i or negedge rst_ni) begin
    logic     start_n, we_n, hold;
    cmd_t     c;
    if (!rst_ni) begin
      start <= 1'b0;
      cfg_we_i <= 1'b0;
      cfg_data_i <= 1'b0;
      in_i <= '0;
    end else begin
      start_n = 1'b0;
      we_n = 1'b0;
      hold = start && busy;
      if (start && !busy) sample_exp_q.push_back(dsf_sample(in_i, mode_shadow));
      quiet_cnt = (!busy && !start && !out_valid_o) ? quiet_cnt + 1 : 0;
      if (hold) begin
        start_n = 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (cmd_q.size() != 0) begin
        c = cmd_q[0];
        if (c.kind == CMD_SAMPLE) begin
          in_i <= c.item;
          start_n = 1'b1;
          void'(cmd_q.pop_front());
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
          end else begin
            burst_left--;
          end
        end else if (quiet_cnt >= 8 && sample_exp_q.size() == 0) begin
          if (c.kind == CMD_MODE) begin
            we_n = 1'b1;
            cfg_data_i <= c.mode;
            mode_shadow = c.mode;
          end
          void'(cmd_q.pop_front());
        end
      end
      start <= start_n;
      cfg_we_i <= we_n;
    end
  end

  // Monitor: every strobe is checked against the oldest expected sample
  always @(posedge clk_i) begin
    dsf_pkg::out_item_t e;
    if (rst_ni && out_valid_o) begin
      if (sample_exp_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_o));
      end else begin
        e = sample_exp_q.pop_front();
        if (out_o.sample_out !== e.sample_out)
          report_mismatch($sformatf("sample_out %0d, expected %0d",
                                    out_o.sample_out, e.sample_out));
        if (out_o.degenerate !== e.degenerate)
          report_mismatch($sformatf("degenerate %b, expected %b",
                                    out_o.degenerate, e.degenerate));
      end
    end
  end

  // Reset, then wait for all transfers to drain
  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (cmd_q.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
    while (start || busy || sample_exp_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
